// ----- hw/rtl/i2p_pkg.sv -----
// Shared codes, character constants and helpers for the infix to postfix converter.
package i2p_pkg;

    // Operator stack entry codes
    localparam logic [2:0] OP_OPEN = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_POW  = 3'd5;
    localparam logic [2:0] OP_NONE = 3'd7;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;
    localparam logic [1:0] ST_OPEN  = 2'd3;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       symbol_valid;
        logic       last;
        logic [1:0] status;
    } res_t;

    function automatic logic [2:0] char_to_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CH_OPEN: code = OP_OPEN;
            CH_ADD:  code = OP_ADD;
            CH_SUB:  code = OP_SUB;
            CH_MUL:  code = OP_MUL;
            CH_DIV:  code = OP_DIV;
            CH_POW:  code = OP_POW;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_to_char(input logic [2:0] code);
        logic [7:0] c;
        unique case (code)
            OP_OPEN: c = CH_OPEN;
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_POW:  c = CH_POW;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] p;
        case (code) inside
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            OP_POW:         p = 2'd3;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/i2p_sym_if.sv -----
// Input channel: one character per request.
interface i2p_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink (input valid, input symbol, output ready);
endinterface

// ----- hw/rtl/i2p_res_if.sv -----
// Output channel: one postfix result item per request.
interface i2p_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output out_symbol, output symbol_valid, output last,
                    output status, input ready);
    modport sink (input valid, input out_symbol, input symbol_valid, input last,
                  input status, output ready);
endinterface

// ----- hw/rtl/i2p_stack_mem.sv -----
// Operator stack storage: one write port, one registered read port.
module i2p_stack_mem #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [2:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [2:0]    rdata
);

    logic [2:0] mem_reg [DEPTH];
    logic [2:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/i2p_out_stage.sv -----
// Output register between the converter core and the result channel.
module i2p_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  i2p_pkg::res_t  item,
    output logic           free,
    output logic           valid,
    input  logic           ready,
    output i2p_pkg::res_t  data
);
    import i2p_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            data_reg <= item;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- hw/rtl/i2p_ctrl.sv -----
// Sequencer: decodes a character, pops and pushes the stack, forms result items.
module i2p_ctrl #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     symbol,
    output logic           mem_we,
    output logic [AW-1:0]  mem_waddr,
    output logic [2:0]     mem_wdata,
    output logic           mem_re,
    output logic [AW-1:0]  mem_raddr,
    input  logic [2:0]     mem_rdata,
    input  logic           out_free,
    output logic           out_wr,
    output i2p_pkg::res_t  out_item
);
    import i2p_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_STEP = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] open_reg, open_next;
    logic [2:0]    top_reg, top_next;
    logic          use_mem_reg, use_mem_next;
    logic [7:0]    sym_reg, sym_next;
    logic [2:0]    code_reg, code_next;
    logic [1:0]    status_reg, status_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_sym_reg, pend_sym_next;

    logic       [2:0] top_cur;
    logic             nonempty;
    logic             full;
    logic       [2:0] in_code;
    logic             in_pops;
    logic             step_pops;
    logic             do_pop;
    logic             pop_emit;
    logic             finish;
    logic             do_push;

    // Top entry is cached after a push, or sits in the read register after a pop
    assign top_cur  = use_mem_reg ? mem_rdata : top_reg;
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign in_code  = char_to_code(symbol);
    assign in_pops  = nonempty && (top_cur != OP_OPEN)
                      && (code_prec(top_cur) >= code_prec(in_code));
    assign step_pops = nonempty && (top_cur != OP_OPEN)
                      && (code_prec(top_cur) >= code_prec(code_reg));
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        do_pop   = 1'b0;
        pop_emit = 1'b0;
        finish   = 1'b0;
        do_push  = 1'b0;
        if (state_reg == S_STEP && out_free)
        begin
            if (sym_reg == CH_HASH)
            begin
                do_pop   = nonempty;
                pop_emit = nonempty && (top_cur != OP_OPEN);
                finish   = !nonempty;
            end
            else if (sym_reg == CH_CLOSE)
            begin
                do_pop   = nonempty;
                pop_emit = nonempty && (top_cur != OP_OPEN);
                finish   = !nonempty || (top_cur == OP_OPEN);
            end
            else if (code_reg == OP_NONE)
            begin
                finish = 1'b1;
            end
            else if (code_reg != OP_OPEN && step_pops)
            begin
                do_pop   = 1'b1;
                pop_emit = 1'b1;
            end
            else
            begin
                finish  = 1'b1;
                do_push = !full;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        top_next        = top_reg;
        use_mem_next    = use_mem_reg;
        sym_next        = sym_reg;
        code_next       = code_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        mem_we          = 1'b0;
        mem_waddr       = AW'(count_reg);
        mem_wdata       = code_reg;
        mem_re          = 1'b0;
        mem_raddr       = AW'(count_reg - CW'(2));
        out_wr          = 1'b0;
        out_item        = '{out_symbol: pend_sym_reg, symbol_valid: 1'b1, last: 1'b0,
                            status: status_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next    = symbol;
                    code_next   = in_code;
                    status_next = ST_OK;
                    if (symbol == CH_HASH)
                    begin
                        if (open_reg != '0)
                        begin
                            status_next = ST_OPEN;
                        end
                    end
                    else if (symbol == CH_CLOSE)
                    begin
                        if (open_reg == '0)
                        begin
                            status_next = ST_CLOSE;
                        end
                    end
                    else if (in_code == OP_OPEN)
                    begin
                        if (full)
                        begin
                            status_next = ST_OVF;
                        end
                    end
                    else if (in_code != OP_NONE)
                    begin
                        // only a first pop can free a slot in a full stack
                        if (full && !in_pops)
                        begin
                            status_next = ST_OVF;
                        end
                    end
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (do_pop)
                begin
                    count_next   = count_reg - CW'(1);
                    mem_re       = (count_reg > CW'(1));
                    use_mem_next = 1'b1;
                    if (top_cur == OP_OPEN)
                    begin
                        open_next = open_reg - CW'(1);
                    end
                end
                if (pop_emit)
                begin
                    // a held item goes out once another one is known to follow
                    out_wr          = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_sym_next   = code_to_char(top_cur);
                end
                if (do_push)
                begin
                    mem_we       = 1'b1;
                    top_next     = code_reg;
                    use_mem_next = 1'b0;
                    count_next   = count_reg + CW'(1);
                    if (code_reg == OP_OPEN)
                    begin
                        open_next = open_reg + CW'(1);
                    end
                end
                if (finish)
                begin
                    out_wr = 1'b1;
                    if (code_reg == OP_NONE && sym_reg != CH_HASH && sym_reg != CH_CLOSE)
                    begin
                        out_item = '{out_symbol: sym_reg, symbol_valid: 1'b1, last: 1'b1,
                                     status: status_reg};
                    end
                    else if (pend_valid_reg)
                    begin
                        out_item = '{out_symbol: pend_sym_reg, symbol_valid: 1'b1,
                                     last: 1'b1, status: status_reg};
                    end
                    else
                    begin
                        out_item = '{out_symbol: 8'h00, symbol_valid: 1'b0, last: 1'b1,
                                     status: status_reg};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            open_reg       <= '0;
            use_mem_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            open_reg       <= open_next;
            use_mem_reg    <= use_mem_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        sym_reg      <= sym_next;
        code_reg     <= code_next;
        status_reg   <= status_next;
        pend_sym_reg <= pend_sym_next;
    end

endmodule

// ----- hw/rtl/infix_to_postfix_converter_unit.sv -----
// Infix to postfix converter: the shunting-yard top level.
// Takes one character per request and returns postfix characters, one per result request,
// the last one of each input marked by last; an input that emits nothing returns a single
// item with symbol_valid low that carries its status. Pending operators live in a
// STACK_DEPTH-entry memory with one write and one registered read port; the top entry is
// also cached so a push needs no read. An input is accepted, then each stack entry it
// pops takes a step of its own (one memory read each), then a finishing step follows; the
// result channel holding ready low stalls these steps. A ')' that finds its '(' pops the
// '(' in the finishing step. An operand is accepted and then finished. The result sits in
// an output register, so the next character can be taken while the last result of the
// previous one still waits. No clearing pass after reset.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    i2p_sym_if.sink   chars,
    i2p_res_if.source postfix
);
    import i2p_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [2:0]    mem_rdata;
    logic          out_free;
    logic          out_wr;
    res_t          out_item;
    res_t          out_data;

    i2p_stack_mem #(.DEPTH(STACK_DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    i2p_ctrl #(.DEPTH(STACK_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .in_ready  (chars.ready),
        .symbol    (chars.symbol),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .out_wr    (out_wr),
        .out_item  (out_item)
    );

    i2p_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (out_wr),
        .item  (out_item),
        .free  (out_free),
        .valid (postfix.valid),
        .ready (postfix.ready),
        .data  (out_data)
    );

    assign postfix.out_symbol   = out_data.out_symbol;
    assign postfix.symbol_valid = out_data.symbol_valid;
    assign postfix.last         = out_data.last;
    assign postfix.status       = out_data.status;

endmodule

// ----- hw/rtl/i2p_checker.sv -----
// Port-level checks for the infix to postfix converter, bound to the top level.
module i2p_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_symbol,
    input logic       symbol_valid,
    input logic       last
);

    // held result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(last))
        else $error("result changed while stalled");

    // an empty item is always the only item of its input
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !symbol_valid |-> last)
        else $error("empty result item not marked last");

    // no new character while an input still has results to come
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken while results still pending");

    // ready drops after each accepted character while the step state works on it
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after a request");

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .out_valid    (postfix.valid),
    .out_ready    (postfix.ready),
    .out_symbol   (postfix.out_symbol),
    .symbol_valid (postfix.symbol_valid),
    .last         (postfix.last)
);
